// ===== hw/rtl/wcrp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcrp_pkg: shared types and constants for the window range prior block.
// Holds the geometry limits, register indexes, state encoding and the
// command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package wcrp_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int PATCH_MAX  = 16;

    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int ROW_W   = $clog2(MAX_HEIGHT);
    localparam int BANK_W  = $clog2(PATCH_MAX);
    localparam int PCNT_W  = $clog2(PATCH_MAX + 1);
    localparam int ADDR_W  = 3;

    localparam logic [ADDR_W-1:0] REG_INV_VEIL0 = 3'd0;
    localparam logic [ADDR_W-1:0] REG_INV_VEIL1 = 3'd1;
    localparam logic [ADDR_W-1:0] REG_INV_VEIL2 = 3'd2;
    localparam logic [ADDR_W-1:0] REG_PATCH     = 3'd3;
    localparam logic [ADDR_W-1:0] REG_WIDTH     = 3'd4;
    localparam logic [ADDR_W-1:0] REG_HEIGHT    = 3'd5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WRITE,
        ST_SCAN,
        ST_DRAIN,
        ST_SCALE,
        ST_MAX,
        ST_OUT
    } wcrp_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // capture input pixel and position
        logic write;      // write pixel into the row store
        logic scan_first; // first store read of the window
        logic scan;       // issue a store read at the window cursor
        logic scale;      // register the three products
        logic pick;       // reduce products to the result
        logic advance;    // step the frame position
    } wcrp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_done;  // cursor issued the last window read
    } wcrp_stat_t;

endpackage

// ===== hw/rtl/wcrp_stream_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcrp_stream_if: valid/ready channel with a generic payload.
// One instance carries pixels in, another carries results out.
// ----------------------------------------------------------------------------
interface wcrp_stream_if #(parameter int W = 24);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/wcrp_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcrp_ctrl: sequencer for one pixel.
// Steps through write, window scan, scaling, reduction and output.
// ----------------------------------------------------------------------------
module wcrp_ctrl
    import wcrp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  wcrp_stat_t stat,
    output wcrp_cmd_t  cmd
);

    wcrp_state_t state_reg;
    wcrp_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // A one-entry window is fully read in the write cycle, so the scan
    // state is skipped.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (in_valid) state_next = ST_WRITE;
            ST_WRITE: state_next = stat.scan_done ? ST_DRAIN : ST_SCAN;
            ST_SCAN:  if (stat.scan_done) state_next = ST_DRAIN;
            ST_DRAIN: state_next = ST_SCALE;
            ST_SCALE: state_next = ST_MAX;
            ST_MAX:   state_next = ST_OUT;
            ST_OUT:   if (out_ready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_WRITE:
            begin
                cmd.write      = 1'b1;
                cmd.scan_first = 1'b1;
            end
            ST_SCAN:  cmd.scan  = 1'b1;
            ST_DRAIN: cmd.scan  = 1'b0;
            ST_SCALE: cmd.scale = 1'b1;
            ST_MAX:   cmd.pick  = 1'b1;
            ST_OUT:
            begin
                out_valid   = 1'b1;
                cmd.advance = out_ready;
            end
            default:  cmd = '0;
        endcase
    end

    a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input and output open together");
    a_out_after_max: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg) == ST_MAX)
        else $error("result shown without reduction");
    a_load_to_write: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> cmd.write)
        else $error("loaded pixel not written");

endmodule

// ===== hw/rtl/wcrp_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcrp_datapath: row store, window scan, min/max tracking and scaling.
// Holds frame position and the configuration registers.
// ----------------------------------------------------------------------------
module wcrp_datapath
    import wcrp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  wcrp_cmd_t         cmd,
    output wcrp_stat_t        stat,
    input  logic [7:0]        pix_ch0,
    input  logic [7:0]        pix_ch1,
    input  logic [7:0]        pix_ch2,
    output logic [23:0]       range_value,
    output logic              frame_end,
    input  logic              cfg_we,
    input  logic [ADDR_W-1:0] cfg_addr,
    input  logic [31:0]       cfg_wdata,
    output logic [31:0]       cfg_rdata
);

    localparam int DEPTH = PATCH_MAX * MAX_WIDTH;
    localparam int MEM_W = BANK_W + COL_W;

    logic [15:0] veil_reg [3];
    logic [4:0]  patch_reg;
    logic [10:0] width_reg;
    logic [10:0] height_reg;
    logic        restart_reg;

    logic [ROW_W-1:0] row_reg;
    logic [COL_W-1:0] col_reg;

    logic [23:0] pix_reg;
    logic [23:0] mem [DEPTH];
    logic [23:0] rd_reg;
    logic        rd_vld_reg;
    logic        rd_vld_next;
    logic [ROW_W:0] cur_r_reg;
    logic [COL_W:0] cur_c_reg;
    logic [7:0]  lo_reg [3];
    logic [7:0]  hi_reg [3];
    logic [23:0] prod_reg [3];
    logic [23:0] best_reg;
    logic        last_reg;

    logic [COL_W:0] w_eff;
    logic [ROW_W:0] h_eff;
    logic [PCNT_W-1:0] p_eff;
    logic [ROW_W+1:0] r_lim;
    logic [COL_W+1:0] c_lim;
    logic [ROW_W:0] r_end;
    logic [COL_W:0] c_end;
    logic [ROW_W-1:0] row_use;
    logic [COL_W-1:0] col_use;
    logic           pos_bad;
    logic [MEM_W-1:0] wr_addr;
    logic [MEM_W-1:0] rd_addr;
    logic [ROW_W:0] cur_r;
    logic [COL_W:0] cur_c;
    logic           last_col;
    logic           last_row;

    always_comb
    begin
        w_eff = (width_reg == 11'd0) ? (COL_W+1)'(1) :
                (width_reg > 11'(MAX_WIDTH)) ? (COL_W+1)'(MAX_WIDTH) : width_reg[COL_W:0];
        h_eff = (height_reg == 11'd0) ? (ROW_W+1)'(1) :
                (height_reg > 11'(MAX_HEIGHT)) ? (ROW_W+1)'(MAX_HEIGHT) :
                height_reg[ROW_W:0];
        p_eff = (patch_reg == 5'd0) ? PCNT_W'(1) :
                (patch_reg > 5'(PATCH_MAX)) ? PCNT_W'(PATCH_MAX) : patch_reg[PCNT_W-1:0];
        pos_bad = restart_reg || ({1'b0, row_reg} >= h_eff) || ({1'b0, col_reg} >= w_eff);
        row_use = pos_bad ? ROW_W'(h_eff - 1'b1) : row_reg;
        col_use = pos_bad ? COL_W'(w_eff - 1'b1) : col_reg;
    end

    // Window bounds from the held position. Every write-cycle or scan-cycle
    // read lies inside the window; scan_done marks the last one.
    always_comb
    begin
        r_lim = (ROW_W+2)'(row_reg) + (ROW_W+2)'(p_eff);
        c_lim = (COL_W+2)'(col_reg) + (COL_W+2)'(p_eff);
        r_end = (r_lim < (ROW_W+2)'(h_eff)) ? r_lim[ROW_W:0] : h_eff;
        c_end = (c_lim < (COL_W+2)'(w_eff)) ? c_lim[COL_W:0] : w_eff;
        cur_r = cmd.scan_first ? (ROW_W+1)'(row_reg) : cur_r_reg;
        cur_c = cmd.scan_first ? (COL_W+1)'(col_reg) : cur_c_reg;
        last_col = (cur_c + 1'b1) >= c_end;
        last_row = (cur_r + 1'b1) >= r_end;
        stat.scan_done = last_col && last_row;
        wr_addr = {row_reg[BANK_W-1:0], col_reg};
        rd_addr = {cur_r[BANK_W-1:0], cur_c[COL_W-1:0]};
        rd_vld_next = cmd.scan_first || cmd.scan;
    end

    // Configuration registers and frame position.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            veil_reg[0] <= 16'd4096;
            veil_reg[1] <= 16'd4096;
            veil_reg[2] <= 16'd4096;
            patch_reg   <= 5'd8;
            width_reg   <= 11'd1024;
            height_reg  <= 11'd1024;
            restart_reg <= 1'b1;
            row_reg     <= '0;
            col_reg     <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                restart_reg <= 1'b0;
                row_reg     <= row_use;
                col_reg     <= col_use;
            end
            else if (cmd.advance)
            begin
                if (col_reg == '0)
                begin
                    col_reg <= COL_W'(w_eff - 1'b1);
                    row_reg <= (row_reg == '0) ? ROW_W'(h_eff - 1'b1) : row_reg - 1'b1;
                end
                else
                begin
                    col_reg <= col_reg - 1'b1;
                end
            end
            if (cfg_we)
            begin
                case (cfg_addr)
                    REG_INV_VEIL0: veil_reg[0] <= cfg_wdata[15:0];
                    REG_INV_VEIL1: veil_reg[1] <= cfg_wdata[15:0];
                    REG_INV_VEIL2: veil_reg[2] <= cfg_wdata[15:0];
                    REG_PATCH:
                    begin
                        patch_reg   <= cfg_wdata[4:0];
                        restart_reg <= 1'b1;
                    end
                    REG_WIDTH:
                    begin
                        width_reg   <= cfg_wdata[10:0];
                        restart_reg <= 1'b1;
                    end
                    REG_HEIGHT:
                    begin
                        height_reg  <= cfg_wdata[10:0];
                        restart_reg <= 1'b1;
                    end
                    default: restart_reg <= restart_reg;
                endcase
            end
        end
    end

    always_comb
    begin
        case (cfg_addr)
            REG_INV_VEIL0: cfg_rdata = {16'd0, veil_reg[0]};
            REG_INV_VEIL1: cfg_rdata = {16'd0, veil_reg[1]};
            REG_INV_VEIL2: cfg_rdata = {16'd0, veil_reg[2]};
            REG_PATCH:     cfg_rdata = {27'd0, patch_reg};
            REG_WIDTH:     cfg_rdata = {21'd0, width_reg};
            REG_HEIGHT:    cfg_rdata = {21'd0, height_reg};
            default:       cfg_rdata = 32'd0;
        endcase
    end

    // Row store: one write port, one registered read port. The anchor pixel
    // is written in the same cycle as its first read.
    always_ff @(posedge clk)
    begin
        if (cmd.write)
        begin
            mem[wr_addr] <= pix_reg;
        end
        rd_reg <= mem[rd_addr];
    end

    // Forward the anchor pixel for the first read, which shares its cycle
    // with the write.
    logic fwd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_vld_reg <= 1'b0;
            fwd_reg    <= 1'b0;
        end
        else
        begin
            rd_vld_reg <= rd_vld_next;
            fwd_reg    <= cmd.scan_first;
        end
    end

    logic [23:0] rd_data;
    assign rd_data = fwd_reg ? pix_reg : rd_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            pix_reg <= {pix_ch2, pix_ch1, pix_ch0};
        end
        if (cmd.scan_first || cmd.scan)
        begin
            if (last_col)
            begin
                cur_c_reg <= (COL_W+1)'(col_reg);
                cur_r_reg <= cur_r + 1'b1;
            end
            else
            begin
                cur_c_reg <= cur_c + 1'b1;
                cur_r_reg <= cur_r;
            end
        end
        for (int k = 0; k < 3; k++)
        begin
            if (cmd.scan_first)
            begin
                lo_reg[k] <= 8'hFF;
                hi_reg[k] <= 8'h00;
            end
            else if (rd_vld_reg)
            begin
                if (rd_data[8*k +: 8] < lo_reg[k]) lo_reg[k] <= rd_data[8*k +: 8];
                if (rd_data[8*k +: 8] > hi_reg[k]) hi_reg[k] <= rd_data[8*k +: 8];
            end
            if (cmd.scale)
            begin
                prod_reg[k] <= 24'(hi_reg[k] - lo_reg[k]) * 24'(veil_reg[k]);
            end
        end
        if (cmd.pick)
        begin
            best_reg <= (prod_reg[0] >= prod_reg[1]) ?
                        ((prod_reg[0] >= prod_reg[2]) ? prod_reg[0] : prod_reg[2]) :
                        ((prod_reg[1] >= prod_reg[2]) ? prod_reg[1] : prod_reg[2]);
            last_reg <= (row_reg == '0) && (col_reg == '0);
        end
    end

    assign range_value = best_reg;
    assign frame_end   = last_reg;

    a_scan_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan |-> (cur_r_reg < r_end) && (cur_c_reg < c_end))
        else $error("scan cursor left the window");
    a_first_after_write: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_first |-> cmd.write)
        else $error("scan started without anchor write");
    a_read_follows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_first |=> rd_vld_reg)
        else $error("first window read lost");

endmodule

// ===== hw/rtl/window_channel_range_prior.sv =====
`timescale 1ns / 1ps
// A pixel's result is valid only after all n entries of its window are read, where
// n is the number of window entries (up to patch_size squared, clipped at the
// frame edge); the row store's single read port reads one entry per cycle.
// The block takes one pixel at a time: the next input transfer is taken only
// after the previous result has been accepted. Reset restores register defaults
// and the bottom-right start.
// ----------------------------------------------------------------------------
// window_channel_range_prior: sliding window range prior over RGB pixels.
// Pixels arrive bottom-right first; each result is the largest per-channel
// window range scaled by that channel's reciprocal veil (Q4.12).
// ----------------------------------------------------------------------------
module window_channel_range_prior
    import wcrp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    wcrp_stream_if.sink       pix_in,
    wcrp_stream_if.source     res_out,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [4:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    // Control bundles between the sequencer and the datapath.
    wcrp_cmd_t  cmd;
    wcrp_stat_t stat;
    logic [23:0] range_value;
    logic        frame_end;
    logic        cfg_we;

    // A register write completes on the access phase; pready is always high.
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    wcrp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pix_in.valid),
        .in_ready  (pix_in.ready),
        .out_valid (res_out.valid),
        .out_ready (res_out.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // The datapath owns the row store, window scan and scaling products.
    wcrp_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .pix_ch0     (pix_in.data[7:0]),
        .pix_ch1     (pix_in.data[15:8]),
        .pix_ch2     (pix_in.data[23:16]),
        .range_value (range_value),
        .frame_end   (frame_end),
        .cfg_we      (cfg_we && (paddr[1:0] == 2'b00) && !(paddr[4] && paddr[3])),
        .cfg_addr    (paddr[4:2]),
        .cfg_wdata   (pwdata),
        .cfg_rdata   (prdata)
    );

    // Result payload: range in the low 24 bits, frame end flag above.
    assign res_out.data = {frame_end, range_value};

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for window_channel_range_prior.
// Streams pixels in reverse raster order over a range of frame and window
// geometries and reciprocal veils. Each result is checked against a hand-typed
// value or a local model of the prior with its own copy of the row store.
// ----------------------------------------------------------------------------
module tb;
    import wcrp_pkg::*;

    localparam int QUIET_LIMIT = 20000;
    localparam int SETTLE      = 300;
    localparam int N_RANDOM    = 1000;

    typedef struct {
        logic [23:0] range_value;
        logic        frame_end;
    } prior_t;

    // One line of the directed part: either a register write or a pixel,
    // optionally with the result typed in by hand.
    typedef struct {
        bit          is_reg;
        logic [2:0]  idx;
        logic [31:0] val;
        logic [23:0] pix;
        bit          typed;
        logic [23:0] range_value;
        bit          frame_end;
    } step_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [4:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    wcrp_stream_if #(.W(24)) pix_in ();
    wcrp_stream_if #(.W(25)) res_out ();

    window_channel_range_prior dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .pix_in  (pix_in.sink),
        .res_out (res_out.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 clk = ~clk;

    // Local copy of the block's state and registers.
    logic [23:0] pixel_rows [PATCH_MAX*MAX_WIDTH];
    int unsigned cur_row, cur_col;
    logic [15:0] veil [3];
    logic [4:0]  patch_reg;
    logic [10:0] width_reg, height_reg;

    prior_t prior_q [$];
    int errors = 0;
    int mismatches = 0;
    bit calm = 1'b0;      // no idling on either side near the end
    int quiet = 0;
    int stall_left = 0;

    function automatic int unsigned clamp(int unsigned v, int unsigned hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic void restart_frame();
        cur_row = clamp(height_reg, MAX_HEIGHT) - 1;
        cur_col = clamp(width_reg, MAX_WIDTH) - 1;
    endfunction

    function automatic void apply_reg(logic [2:0] idx, logic [31:0] val);
        case (idx)
            REG_INV_VEIL0: veil[0] = val[15:0];
            REG_INV_VEIL1: veil[1] = val[15:0];
            REG_INV_VEIL2: veil[2] = val[15:0];
            REG_PATCH:  begin patch_reg  = val[4:0];  restart_frame(); end
            REG_WIDTH:  begin width_reg  = val[10:0]; restart_frame(); end
            REG_HEIGHT: begin height_reg = val[10:0]; restart_frame(); end
            default: ;
        endcase
    endfunction

    // Store the pixel, then take the per-channel range over the forward
    // window (clipped at the frame edge) and keep the largest scaled one.
    function automatic prior_t predict_prior(logic [23:0] px);
        int unsigned w, h, p, r_end, c_end, row, col;
        int unsigned lo [3];
        int unsigned hi [3];
        int unsigned s, prod, best;
        prior_t res;
        w = clamp(width_reg, MAX_WIDTH);
        h = clamp(height_reg, MAX_HEIGHT);
        p = clamp(patch_reg, PATCH_MAX);
        if (cur_row >= h || cur_col >= w) restart_frame();
        row = cur_row;
        col = cur_col;
        pixel_rows[(row % PATCH_MAX) * MAX_WIDTH + col] = px;
        r_end = (row + p < h) ? row + p : h;
        c_end = (col + p < w) ? col + p : w;
        for (int ch = 0; ch < 3; ch++) begin
            lo[ch] = 255;
            hi[ch] = 0;
        end
        for (int unsigned r = row; r < r_end; r++)
            for (int unsigned c = col; c < c_end; c++)
                for (int ch = 0; ch < 3; ch++) begin
                    s = pixel_rows[(r % PATCH_MAX) * MAX_WIDTH + c][8*ch +: 8];
                    if (s < lo[ch]) lo[ch] = s;
                    if (s > hi[ch]) hi[ch] = s;
                end
        best = 0;
        for (int ch = 0; ch < 3; ch++) begin
            prod = (hi[ch] - lo[ch]) * veil[ch];
            if (prod > best) best = prod;
        end
        res.range_value = best[23:0];
        res.frame_end = (row == 0 && col == 0);
        if (col == 0) begin
            cur_col = w - 1;
            cur_row = (row == 0) ? h - 1 : row - 1;
        end else begin
            cur_col = col - 1;
        end
        return res;
    endfunction

    // Result side: random stall bursts, and the check of every transfer.
    always @(posedge clk) begin
        if (res_out.valid && res_out.ready) begin
            if (prior_q.size() == 0) begin
                errors++;
                mismatches++;
                if (mismatches <= 10)
                    $display("result with nothing expected: range=%0d end=%0b",
                             res_out.data[23:0], res_out.data[24]);
            end else begin
                prior_t exp_r;
                exp_r = prior_q.pop_front();
                if (res_out.data[23:0] !== exp_r.range_value ||
                    res_out.data[24] !== exp_r.frame_end) begin
                    errors++;
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected range=%0d end=%0b, got range=%0d end=%0b",
                                 exp_r.range_value, exp_r.frame_end,
                                 res_out.data[23:0], res_out.data[24]);
                end
            end
        end
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            res_out.ready <= 1'b0;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 17);
            res_out.ready <= 1'b0;
        end else begin
            res_out.ready <= 1'b1;
        end
    end

    // Watchdog: any transfer on any port resets the count of quiet cycles.
    always @(posedge clk) begin
        if ((pix_in.valid && pix_in.ready) || (res_out.valid && res_out.ready) ||
            (psel && penable))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet > QUIET_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Setup cycle, then access cycle; pready is always high.
    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        apply_reg(idx, val);
    endtask

    // Registers change only when every result is in and the block is idle.
    task automatic wait_idle();
        while (prior_q.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // One pixel transfer; a random gap of idle cycles may come first.
    task automatic send_pixel(logic [23:0] px, bit typed, prior_t typed_res);
        prior_t pred;
        if (!calm && $urandom_range(0, 4) == 0) begin
            pix_in.valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        pix_in.valid <= 1'b1;
        pix_in.data <= px;
        pred = predict_prior(px);
        prior_q.push_back(typed ? typed_res : pred);
        @(posedge clk);
        while (!pix_in.ready) @(posedge clk);
    endtask

    function automatic logic [23:0] rand_pixel();
        return 24'($urandom_range(0, 24'hFFFFFF));
    endfunction

    step_t steps [$];

    initial begin
        prior_t res;
        int unsigned sent, w, h, n;
        pix_in.valid = 1'b0;
        pix_in.data = '0;
        veil[0] = 16'd4096;
        veil[1] = 16'd4096;
        veil[2] = 16'd4096;
        patch_reg = 5'd8;
        width_reg = 11'd1024;
        height_reg = 11'd1024;
        restart_frame();

        // Directed part. A zero patch acts as one; a 1x1 frame ends on
        // every pixel with no range.
        steps = '{
            '{1, REG_PATCH,     32'd0,     0, 0, 0, 0},
            '{1, REG_WIDTH,     32'd1,     0, 0, 0, 0},
            '{1, REG_HEIGHT,    32'd1,     0, 0, 0, 0},
            '{0, 0, 0, 24'hFFFFFF, 1, 24'd0, 1},
            '{0, 0, 0, 24'h000000, 1, 24'd0, 1},
            // 2x2 frame, 2x2 window, full-scale and zero veils.
            '{1, REG_WIDTH,     32'd2,     0, 0, 0, 0},
            '{1, REG_HEIGHT,    32'd2,     0, 0, 0, 0},
            '{1, REG_PATCH,     32'd2,     0, 0, 0, 0},
            '{1, REG_INV_VEIL0, 32'd65535, 0, 0, 0, 0},
            '{1, REG_INV_VEIL1, 32'd0,     0, 0, 0, 0},
            '{0, 0, 0, 24'h0000FF, 1, 24'd0, 0},
            '{0, 0, 0, 24'h00FF00, 1, 24'd16711425, 0},
            '{0, 0, 0, 24'hFF0000, 1, 24'd16711425, 0},
            '{0, 0, 0, 24'h000000, 1, 24'd16711425, 1},
            // Frame wraps back to bottom-right; the veil change needs no restart.
            '{1, REG_INV_VEIL0, 32'd0,     0, 0, 0, 0},
            '{0, 0, 0, 24'h00FF00, 1, 24'd0, 0},
            '{0, 0, 0, 24'hFF00FF, 0, 0, 0},
            // Oversize geometry clamps to the maxima; a zero height acts as one.
            '{1, REG_INV_VEIL2, 32'd65535, 0, 0, 0, 0},
            '{1, REG_WIDTH,     32'd2047,  0, 0, 0, 0},
            '{1, REG_HEIGHT,    32'd0,     0, 0, 0, 0},
            '{1, REG_PATCH,     32'd31,    0, 0, 0, 0},
            '{0, 0, 0, 24'h123456, 0, 0, 0},
            '{0, 0, 0, 24'hFEDCBA, 0, 0, 0},
            '{0, 0, 0, 24'h00FF00, 0, 0, 0}
        };

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        foreach (steps[i]) begin
            if (steps[i].is_reg) begin
                // Drop valid so the last pixel is not taken a second time.
                pix_in.valid <= 1'b0;
                wait_idle();
                write_reg(steps[i].idx, steps[i].val);
            end else begin
                res.range_value = steps[i].range_value;
                res.frame_end = steps[i].frame_end;
                send_pixel(steps[i].pix, steps[i].typed, res);
            end
        end
        pix_in.valid <= 1'b0;

        // Random part: each phase sets new geometry and/or veils, then streams
        // whole frames or a partial one. Most frames are small; wide or tall
        // extremes come with the other side kept to a single row or column.
        sent = 0;
        while (sent < N_RANDOM) begin
            wait_idle();
            if (sent > N_RANDOM * 85 / 100) calm = 1'b1;
            for (int ch = 0; ch < 3; ch++)
                if ($urandom_range(0, 1)) write_reg(3'(REG_INV_VEIL0 + ch), $urandom());
            if ($urandom_range(0, 2) != 0) begin
                case ($urandom_range(0, 9))
                    0: begin w = $urandom_range(1000, 2047); h = $urandom_range(0, 1); end
                    1: begin w = $urandom_range(0, 1); h = $urandom_range(1000, 2047); end
                    default: begin w = $urandom_range(0, 24); h = $urandom_range(0, 16); end
                endcase
                write_reg(REG_PATCH, $urandom_range(0, 31));
                write_reg(REG_WIDTH, w);
                write_reg(REG_HEIGHT, h);
            end
            n = clamp(width_reg, MAX_WIDTH) * clamp(height_reg, MAX_HEIGHT);
            if (n > 200 || $urandom_range(0, 3) == 0) n = $urandom_range(1, 200);
            else n = n * $urandom_range(1, 2);
            for (int unsigned k = 0; k < n; k++) begin
                send_pixel(rand_pixel(), 1'b0, res);
                sent++;
            end
            pix_in.valid <= 1'b0;
        end

        while (prior_q.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (errors == 0 && prior_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
